// ----- hw/rtl/fhc_pkg.sv -----
package fhc_pkg;

  localparam int MAX_HITS  = 256;
  localparam int COUNT_CAP = (MAX_HITS < 256) ? MAX_HITS : 256;

  localparam int SEG_W   = 8;
  localparam int POS_W   = 13;
  localparam int ADC_W   = 12;
  localparam int LAYER_W = 4;
  localparam int NUM_W   = 8;
  localparam int CNT_W   = 9;
  localparam int LX_W    = 13;
  localparam int SUM_W   = 21;
  localparam int ADCS_W  = 20;
  localparam int OFS_W   = 8;

  localparam logic [OFS_W-1:0]  OFFSET_RESET = 8'd8;
  localparam logic [CNT_W-1:0]  CNT_SAT      = 9'd256;
  localparam logic [ADCS_W-1:0] ADC_SAT      = 20'hFFFFF;
  localparam logic [LX_W-1:0]   LX_SAT       = 13'h1FFF;
  localparam logic [SUM_W-1:0]  MEAN_POS_MAX = 21'd4095;
  localparam logic [SUM_W-1:0]  MEAN_NEG_MAX = 21'd4096;

  localparam int DIV_STEPS = SUM_W;
  localparam int DIV_CW    = $clog2(DIV_STEPS);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_DIV,
    ST_OUT,
    ST_CHECK
  } state_e;

  typedef struct packed {
    logic latch;
    logic extend;
    logic open;
    logic clear;
    logic emit;
    logic emit_last;
  } ctrl_cmd_t;

  typedef struct packed {
    logic cluster_open;
    logic joins;
    logic hit_last;
    logic div_done;
  } dp_status_t;

endpackage

// ----- hw/rtl/fhc_divider.sv -----
module fhc_divider (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic signed [fhc_pkg::SUM_W-1:0]  dividend_i,
  input  logic        [fhc_pkg::CNT_W-1:0]  divisor_i,
  output logic                              done_o,
  output logic signed [fhc_pkg::POS_W-1:0]  quotient_o
);
  import fhc_pkg::*;

  logic                busy_q, busy_d;
  logic [DIV_CW-1:0]   cnt_q, cnt_d;
  logic [CNT_W-1:0]    rem_q, rem_d;
  logic [SUM_W-1:0]    quo_q, quo_d;
  logic [CNT_W-1:0]    dvs_q, dvs_d;
  logic                neg_q, neg_d;
  logic [CNT_W:0]      trial;
  logic [CNT_W:0]      trial_sub;
  logic                ge;

  assign trial     = {rem_q, quo_q[SUM_W-1]};
  assign ge        = trial >= {1'b0, dvs_q};
  assign trial_sub = trial - {1'b0, dvs_q};
  assign done_o    = busy_q && (cnt_q == '0);

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    neg_d  = neg_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = DIV_CW'(DIV_STEPS - 1);
      rem_d  = '0;
      neg_d  = dividend_i[SUM_W-1];
      quo_d  = dividend_i[SUM_W-1] ? (~dividend_i + 1'b1) : dividend_i;
      dvs_d  = (divisor_i == '0) ? CNT_W'(1) : divisor_i;
    end else if (busy_q) begin
      rem_d = ge ? trial_sub[CNT_W-1:0] : trial[CNT_W-1:0];
      quo_d = {quo_q[SUM_W-2:0], ge};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
    neg_q <= neg_d;
  end

  always_comb begin
    if (!neg_q) begin
      quotient_o = (quo_q > MEAN_POS_MAX) ? POS_W'(MEAN_POS_MAX) : quo_q[POS_W-1:0];
    end else if (quo_q > MEAN_NEG_MAX) begin
      quotient_o = POS_W'(MEAN_NEG_MAX);
    end else begin
      quotient_o = ~quo_q[POS_W-1:0] + 1'b1;
    end
  end

endmodule

// ----- hw/rtl/fhc_datapath.sv -----
module fhc_datapath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  fhc_pkg::ctrl_cmd_t                  cmd_i,
  output fhc_pkg::dp_status_t                 status_o,
  input  logic                                cfg_we_i,
  input  logic        [fhc_pkg::OFS_W-1:0]    cfg_wdata_i,
  input  logic        [fhc_pkg::SEG_W-1:0]    segment_i,
  input  logic signed [fhc_pkg::POS_W-1:0]    position_q4_i,
  input  logic        [fhc_pkg::ADC_W-1:0]    adc_value_i,
  input  logic        [fhc_pkg::LAYER_W-1:0]  layer_id_i,
  input  logic                                last_in_layer_i,
  output logic        [fhc_pkg::LAYER_W-1:0]  out_layer_o,
  output logic        [fhc_pkg::NUM_W-1:0]    cluster_number_o,
  output logic        [fhc_pkg::CNT_W-1:0]    cluster_size_o,
  output logic        [fhc_pkg::CNT_W-1:0]    lz_size_o,
  output logic        [fhc_pkg::LX_W-1:0]     lx_size_q4_o,
  output logic signed [fhc_pkg::POS_W-1:0]    cluster_mean_pos_o,
  output logic        [fhc_pkg::ADCS_W-1:0]   cluster_adc_sum_o,
  output logic                                last_of_run_o
);
  import fhc_pkg::*;

  logic        [SEG_W-1:0]   seg_q;
  logic signed [POS_W-1:0]   pos_q;
  logic        [ADC_W-1:0]   adc_q;
  logic        [LAYER_W-1:0] layer_q;
  logic                      last_q;

  logic [OFS_W-1:0]          offset_q;

  logic                      open_q, open_d;
  logic [SEG_W-1:0]          newest_q, newest_d;
  logic                      older_vld_q, older_vld_d;
  logic [SEG_W-1:0]          older_q, older_d;
  logic [CNT_W-1:0]          count_q, count_d;
  logic [CNT_W-1:0]          lz_q, lz_d;
  logic [CNT_W-1:0]          lx_q, lx_d;
  logic signed [SUM_W-1:0]   sum_q, sum_d;
  logic [ADCS_W-1:0]         adc_tot_q, adc_tot_d;
  logic [NUM_W-1:0]          num_q, num_d;

  logic [LAYER_W-1:0]        res_layer_q;
  logic [NUM_W-1:0]          res_num_q;
  logic [CNT_W-1:0]          res_size_q;
  logic [CNT_W-1:0]          res_lz_q;
  logic [LX_W-1:0]           res_lx_q;
  logic [ADCS_W-1:0]         res_adc_q;
  logic                      res_last_q;

  logic                      step1, step2, older2, joins;
  logic                      div_done;
  logic [ADCS_W:0]           adc_add;
  logic [LX_W:0]             lx_calc;
  logic [LX_W-1:0]           lx_sat;

  assign step1  = {1'b0, seg_q} == ({1'b0, newest_q} + 9'd1);
  assign step2  = {1'b0, seg_q} == ({1'b0, newest_q} + 9'd2);
  assign older2 = older_vld_q && ({1'b0, seg_q} == ({1'b0, older_q} + 9'd2));
  assign joins  = open_q && (step1 || step2);

  assign status_o.cluster_open = open_q;
  assign status_o.joins        = joins;
  assign status_o.hit_last     = last_q;
  assign status_o.div_done     = div_done;

  assign adc_add = {1'b0, adc_tot_q} + (ADCS_W + 1)'(adc_q);
  assign lx_calc = {1'b0, lx_q, 4'b0000} + (LX_W + 1)'(lz_q[0] ? '0 : offset_q);
  assign lx_sat  = lx_calc[LX_W] ? LX_SAT : lx_calc[LX_W-1:0];

  always_comb begin
    open_d      = open_q;
    newest_d    = newest_q;
    older_vld_d = older_vld_q;
    older_d     = older_q;
    count_d     = count_q;
    lz_d        = lz_q;
    lx_d        = lx_q;
    sum_d       = sum_q;
    adc_tot_d   = adc_tot_q;
    num_d       = num_q;
    if (cmd_i.extend) begin
      if (step1 && (lz_q < CNT_SAT)) begin
        lz_d = lz_q + 1'b1;
      end
      if ((step2 || older2) && (lx_q < CNT_SAT)) begin
        lx_d = lx_q + 1'b1;
      end
      older_d     = newest_q;
      older_vld_d = 1'b1;
      newest_d    = seg_q;
      if (count_q < CNT_W'(COUNT_CAP)) begin
        count_d   = count_q + 1'b1;
        sum_d     = sum_q + SUM_W'(pos_q);
        adc_tot_d = adc_add[ADCS_W] ? ADC_SAT : adc_add[ADCS_W-1:0];
      end
    end else if (cmd_i.open) begin
      open_d      = 1'b1;
      newest_d    = seg_q;
      older_vld_d = 1'b0;
      older_d     = '0;
      count_d     = CNT_W'(1);
      lz_d        = CNT_W'(1);
      lx_d        = CNT_W'(1);
      sum_d       = SUM_W'(pos_q);
      adc_tot_d   = ADCS_W'(adc_q);
    end else if (cmd_i.clear) begin
      open_d      = 1'b0;
      newest_d    = '0;
      older_vld_d = 1'b0;
      older_d     = '0;
      count_d     = '0;
      lz_d        = CNT_W'(1);
      lx_d        = CNT_W'(1);
      sum_d       = '0;
      adc_tot_d   = '0;
      num_d       = '0;
    end else if (cmd_i.emit) begin
      num_d = num_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q    <= OFFSET_RESET;
      open_q      <= 1'b0;
      newest_q    <= '0;
      older_vld_q <= 1'b0;
      older_q     <= '0;
      count_q     <= '0;
      lz_q        <= CNT_W'(1);
      lx_q        <= CNT_W'(1);
      sum_q       <= '0;
      adc_tot_q   <= '0;
      num_q       <= '0;
    end else begin
      if (cfg_we_i) begin
        offset_q <= cfg_wdata_i;
      end
      open_q      <= open_d;
      newest_q    <= newest_d;
      older_vld_q <= older_vld_d;
      older_q     <= older_d;
      count_q     <= count_d;
      lz_q        <= lz_d;
      lx_q        <= lx_d;
      sum_q       <= sum_d;
      adc_tot_q   <= adc_tot_d;
      num_q       <= num_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      seg_q   <= segment_i;
      pos_q   <= position_q4_i;
      adc_q   <= adc_value_i;
      layer_q <= layer_id_i;
      last_q  <= last_in_layer_i;
    end
    if (cmd_i.emit) begin
      res_layer_q <= layer_q;
      res_num_q   <= num_q;
      res_size_q  <= count_q;
      res_lz_q    <= lz_q;
      res_lx_q    <= lx_sat;
      res_adc_q   <= adc_tot_q;
      res_last_q  <= cmd_i.emit_last;
    end
  end

  fhc_divider u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.emit),
    .dividend_i (sum_q),
    .divisor_i  (count_q),
    .done_o     (div_done),
    .quotient_o (cluster_mean_pos_o)
  );

  assign out_layer_o       = res_layer_q;
  assign cluster_number_o  = res_num_q;
  assign cluster_size_o    = res_size_q;
  assign lz_size_o         = res_lz_q;
  assign lx_size_q4_o      = res_lx_q;
  assign cluster_adc_sum_o = res_adc_q;
  assign last_of_run_o     = res_last_q;

endmodule

// ----- hw/rtl/fhc_controller.sv -----
module fhc_controller (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  input  fhc_pkg::dp_status_t  status_i,
  output fhc_pkg::ctrl_cmd_t   cmd_o
);
  import fhc_pkg::*;

  state_e state_q, state_d;
  logic   final_q, final_d;

  always_comb begin
    state_d = state_q;
    final_d = final_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (status_i.cluster_open && !status_i.joins) begin
          final_d = 1'b0;
          state_d = ST_DIV;
        end else begin
          state_d = ST_CHECK;
        end
      end
      ST_DIV: begin
        if (status_i.div_done) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_stall_i) begin
          state_d = final_q ? ST_IDLE : ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (status_i.hit_last) begin
          final_d = 1'b1;
          state_d = ST_DIV;
        end else begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    in_stall_o  = 1'b1;
    out_valid_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_stall_o  = 1'b0;
        cmd_o.latch = in_valid_i;
      end
      ST_DECIDE: begin
        if (status_i.cluster_open && !status_i.joins) begin
          cmd_o.emit      = 1'b1;
          cmd_o.emit_last = !status_i.hit_last;
        end else if (status_i.cluster_open) begin
          cmd_o.extend = 1'b1;
        end else begin
          cmd_o.open = 1'b1;
        end
      end
      ST_DIV: begin
      end
      ST_OUT: begin
        out_valid_o = 1'b1;
        if (!out_stall_i) begin
          cmd_o.clear = final_q;
          cmd_o.open  = !final_q;
        end
      end
      ST_CHECK: begin
        if (status_i.hit_last) begin
          cmd_o.emit      = 1'b1;
          cmd_o.emit_last = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      final_q <= 1'b0;
    end else begin
      state_q <= state_d;
      final_q <= final_d;
    end
  end

endmodule

// ----- hw/rtl/fiber_hit_clusterer.sv -----
// Groups the fiber hits of one layer, sorted by segment, into clusters.
// Hits arrive as words on the input channel (in_valid_i, in_stall_o); a word
// is taken at a clock edge with in_valid_i high and in_stall_o low. Closed
// clusters leave as words on the output channel (out_valid_o, out_stall_i).
// The block works on one hit at a time and stalls its input until that hit
// is finished. Each cluster it closes is captured in the cycle that starts
// the bit-serial divider that forms the mean position; once the divider is
// done, the word is held on the output until the receiver takes it.
// A hit may close two clusters, the open one and, on the last hit of a layer,
// the one it ends in; last_of_run_o marks the final word for that hit.
// While the receiver stalls, the output word is held and no new hit is taken.
// The user must write the offset register through cfg_we_i and cfg_wdata_i
// only while the block is idle; the block itself does not enforce this.
// Reset clears the cluster, sets the cluster number to zero and the offset
// to 8.
module fiber_hit_clusterer (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic        [fhc_pkg::OFS_W-1:0]    cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic        [fhc_pkg::SEG_W-1:0]    segment_i,
  input  logic signed [fhc_pkg::POS_W-1:0]    position_q4_i,
  input  logic        [fhc_pkg::ADC_W-1:0]    adc_value_i,
  input  logic        [fhc_pkg::LAYER_W-1:0]  layer_id_i,
  input  logic                                last_in_layer_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic        [fhc_pkg::LAYER_W-1:0]  out_layer_o,
  output logic        [fhc_pkg::NUM_W-1:0]    cluster_number_o,
  output logic        [fhc_pkg::CNT_W-1:0]    cluster_size_o,
  output logic        [fhc_pkg::CNT_W-1:0]    lz_size_o,
  output logic        [fhc_pkg::LX_W-1:0]     lx_size_q4_o,
  output logic signed [fhc_pkg::POS_W-1:0]    cluster_mean_pos_o,
  output logic        [fhc_pkg::ADCS_W-1:0]   cluster_adc_sum_o,
  output logic                                last_of_run_o
);
  import fhc_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  fhc_controller u_controller (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  fhc_datapath u_datapath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .status_o           (status),
    .cfg_we_i           (cfg_we_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .segment_i          (segment_i),
    .position_q4_i      (position_q4_i),
    .adc_value_i        (adc_value_i),
    .layer_id_i         (layer_id_i),
    .last_in_layer_i    (last_in_layer_i),
    .out_layer_o        (out_layer_o),
    .cluster_number_o   (cluster_number_o),
    .cluster_size_o     (cluster_size_o),
    .lz_size_o          (lz_size_o),
    .lx_size_q4_o       (lx_size_q4_o),
    .cluster_mean_pos_o (cluster_mean_pos_o),
    .cluster_adc_sum_o  (cluster_adc_sum_o),
    .last_of_run_o      (last_of_run_o)
  );

  a_no_word_after_accept: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> !out_valid_o
  ) else $error("output word raised directly after a hit was taken");

  a_stall_after_early_word: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && !last_of_run_o) |=> (in_stall_o && !out_valid_o)
  ) else $error("hit finished before its final word");

  a_cluster_not_empty: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((cluster_size_o != '0) && (lz_size_o != '0))
  ) else $error("empty cluster emitted");

  a_busy_while_word_out: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o
  ) else $error("hit taken while a word waits");

endmodule
